>>> rtl/cscan_disk_scheduler_defines.svh
// Assertion macros used by the scheduler top level.
// Each macro expands to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef CSCAN_DISK_SCHEDULER_DEFINES_SVH
`define CSCAN_DISK_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CSCAN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cscan: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CSCAN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cscan: next-cycle check failed");

`else

`define CSCAN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CSCAN_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/cscan_pkg.sv
`default_nettype none

package cscan_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int TRACK_W      = 16;
    localparam int TOTAL_W      = TRACK_W + 1;
    localparam int SUM_W        = 22;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int ADDR_W       = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int EMIT_W       = $clog2(MAX_REQUESTS + 4);
    localparam int EXT_W        = 2;
    localparam int CFG_IDX_W    = 1;

    localparam logic [TRACK_W-1:0]   TRACK_MAX = '1;
    // Number of positions added to the requests: track 0, head and top.
    localparam logic [EXT_W-1:0]     EXT_N     = EXT_W'(3);

    localparam logic [CFG_IDX_W-1:0] REG_HEAD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = CFG_IDX_W'(1);

    typedef struct packed {
        logic [TRACK_W-1:0] head;
        logic [TRACK_W-1:0] top;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [TRACK_W-1:0] value;
        logic [ADDR_W-1:0]  count;
    } t_ins_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } t_emit_req;

    function automatic logic [TRACK_W-1:0] sat_track(input logic [TRACK_W-1:0] v,
                                                     input logic [TRACK_W-1:0] top);
        return (v > top) ? top : v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cscan_cfg.sv
`default_nettype none

module cscan_cfg import cscan_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TOTAL_W-1:0]   i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [TRACK_W-1:0] r_head;
    logic [TRACK_W-1:0] r_top;
    logic [TRACK_W-1:0] n_top;
    logic [TOTAL_W-1:0] total_m1;

    assign o_cfg_ready = 1'b1;

    // The highest track is kept instead of the track count itself.
    assign total_m1 = i_cfg_data - TOTAL_W'(1);

    always_comb begin
        if (i_cfg_data == '0) begin
            n_top = '0;
        end else if (total_m1 > {1'b0, TRACK_MAX}) begin
            n_top = TRACK_MAX;
        end else begin
            n_top = total_m1[TRACK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_top  <= TRACK_MAX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HEAD:  r_head <= i_cfg_data[TRACK_W-1:0];
                REG_TOTAL: r_top  <= n_top;
                default: ;
            endcase
        end
    end

    assign o_cfg.head = r_head;
    assign o_cfg.top  = r_top;

endmodule

`default_nettype wire

>>> rtl/cscan_store.sv
`default_nettype none

module cscan_store import cscan_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ins_req           i_ins,
    output logic               o_ins_done,
    input  t_rd_req            i_rd,
    output logic [TRACK_W-1:0] o_rd_data
);

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_CMP} t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    logic [TRACK_W-1:0] r_val, n_val;
    logic [TRACK_W-1:0] r_rdata;
    logic [TRACK_W-1:0] mem [MAX_REQUESTS];

    logic               we;
    logic [TRACK_W-1:0] wdata;
    logic               ins_re;
    logic               re;
    logic [ADDR_W-1:0]  raddr;

    // Insertion walks down from the hole at the end of the list. Each step
    // reads the entry below the hole and either moves it up or drops the new
    // value into the hole. The read (hole - 1) and the write (hole) never
    // touch the same entry in one cycle.
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_val      = r_val;
        we         = 1'b0;
        wdata      = r_val;
        ins_re     = 1'b0;
        o_ins_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_ins.start) begin
                    n_val   = i_ins.value;
                    n_pos   = i_ins.count;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_pos == '0) begin
                    we         = 1'b1;
                    o_ins_done = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    ins_re  = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                we = 1'b1;
                if (r_rdata > r_val) begin
                    wdata   = r_rdata;
                    n_pos   = r_pos - 1'b1;
                    n_state = S_LOOK;
                end else begin
                    o_ins_done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The emitter only reads while no insertion runs.
    assign re    = ins_re | i_rd.en;
    assign raddr = ins_re ? (r_pos - 1'b1) : i_rd.addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pos <= n_pos;
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_pos] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    assign o_rd_data = r_rdata;

endmodule

`default_nettype wire

>>> rtl/cscan_emit.sv
`default_nettype none

module cscan_emit import cscan_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_emit_req          i_start,
    output logic               o_done,
    output t_rd_req            o_rd,
    input  logic [TRACK_W-1:0] i_rd_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [TRACK_W-1:0] o_service_track,
    output logic [TRACK_W-1:0] o_move_distance,
    output logic [SUM_W-1:0]   o_total_movement,
    output logic               o_last_out
);

    typedef enum logic [1:0] {E_IDLE, E_FETCH, E_PICK} t_state;

    t_state             r_state, n_state;
    logic               r_pass, n_pass;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_ri, n_ri;
    logic [EXT_W-1:0]   r_ei, n_ei;
    logic [EMIT_W-1:0]  r_emitted, n_emitted;
    logic [TRACK_W-1:0] r_ext_lo, n_ext_lo;
    logic [TRACK_W-1:0] r_ext_hi, n_ext_hi;
    logic [TRACK_W-1:0] r_prev, n_prev;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic               r_out_valid, n_out_valid;
    logic [TRACK_W-1:0] r_track, n_track;
    logic [TRACK_W-1:0] r_dist, n_dist;
    logic               r_last, n_last;

    logic               req_ok;
    logic               ext_ok;
    logic [TRACK_W-1:0] rv;
    logic [TRACK_W-1:0] ev;
    logic               take_req;
    logic [TRACK_W-1:0] v;
    logic               keep;
    logic               slot_free;
    logic [TRACK_W-1:0] move_dist;

    assign req_ok    = r_ri < r_cnt;
    assign ext_ok    = r_ei != EXT_N;
    assign rv        = sat_track(i_rd_data, i_cfg.top);
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (r_ei)
            EXT_W'(0): ev = '0;
            EXT_W'(1): ev = r_ext_lo;
            default:   ev = r_ext_hi;
        endcase
    end

    // Merge of the sorted store with the three added positions. The first
    // pass keeps positions at or above the head, the second those below it.
    assign take_req = req_ok && (!ext_ok || rv < ev);
    assign v        = take_req ? rv : ev;
    assign keep     = r_pass ? (v < i_cfg.head) : (v >= i_cfg.head);
    assign move_dist = (r_emitted == '0) ? '0 : ((v >= r_prev) ? v - r_prev : r_prev - v);

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_cnt       = r_cnt;
        n_ri        = r_ri;
        n_ei        = r_ei;
        n_emitted   = r_emitted;
        n_ext_lo    = r_ext_lo;
        n_ext_hi    = r_ext_hi;
        n_prev      = r_prev;
        n_sum       = r_sum;
        n_track     = r_track;
        n_dist      = r_dist;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        o_done      = 1'b0;
        o_rd.en     = 1'b0;
        o_rd.addr   = r_ri[ADDR_W-1:0];
        unique case (r_state)
            E_IDLE: begin
                if (i_start.start) begin
                    n_cnt     = i_start.count;
                    n_ri      = '0;
                    n_ei      = '0;
                    n_pass    = 1'b0;
                    n_emitted = '0;
                    n_sum     = '0;
                    n_ext_lo  = (i_cfg.head < i_cfg.top) ? i_cfg.head : i_cfg.top;
                    n_ext_hi  = (i_cfg.head < i_cfg.top) ? i_cfg.top : i_cfg.head;
                    n_state   = E_FETCH;
                end
            end
            E_FETCH: begin
                o_rd.en = req_ok;
                n_state = E_PICK;
            end
            E_PICK: begin
                if (!req_ok && !ext_ok) begin
                    if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_ri    = '0;
                        n_ei    = '0;
                        n_state = E_FETCH;
                    end else if (slot_free) begin
                        // The running total lives in the result register, so
                        // the walk ends only once the final item is taken.
                        o_done  = 1'b1;
                        n_state = E_IDLE;
                    end
                end else if (!keep || slot_free) begin
                    if (take_req) begin
                        n_ri    = r_ri + 1'b1;
                        n_state = E_FETCH;
                    end else begin
                        n_ei = r_ei + 1'b1;
                    end
                    if (keep) begin
                        n_out_valid = 1'b1;
                        n_track     = v;
                        n_dist      = move_dist;
                        n_sum       = r_sum + SUM_W'(move_dist);
                        n_last      = r_emitted == (EMIT_W'(r_cnt) + EMIT_W'(2));
                        n_prev      = v;
                        n_emitted   = r_emitted + 1'b1;
                    end
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_pass    <= n_pass;
        r_cnt     <= n_cnt;
        r_ri      <= n_ri;
        r_ei      <= n_ei;
        r_emitted <= n_emitted;
        r_ext_lo  <= n_ext_lo;
        r_ext_hi  <= n_ext_hi;
        r_prev    <= n_prev;
        r_sum     <= n_sum;
        r_track   <= n_track;
        r_dist    <= n_dist;
        r_last    <= n_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_service_track  = r_track;
    assign o_move_distance  = r_dist;
    assign o_total_movement = r_sum;
    assign o_last_out       = r_last;

endmodule

`default_nettype wire

>>> rtl/cscan_disk_scheduler.sv
// The block takes a new request only once the insertion walk of the previous one through the
// sorted store has ended, and takes none while a batch is being emitted.
// Reset (synchronous, active low) empties the batch, sets head to 0 and the track count
// to 65536; the sorted store itself is not cleared and needs no clearing pass.
`default_nettype none
`include "cscan_disk_scheduler_defines.svh"

module cscan_disk_scheduler import cscan_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TOTAL_W-1:0]   i_cfg_data,

    // Request channel.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [TRACK_W-1:0]   i_request_track,
    input  logic                 i_last_request,

    // Schedule channel.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [TRACK_W-1:0]   o_service_track,
    output logic [TRACK_W-1:0]   o_move_distance,
    output logic [SUM_W-1:0]     o_total_movement,
    output logic                 o_last_out
);

    // The block works in three phases. While idle it takes one request item,
    // saturates it to the highest track and hands it to the store, which
    // inserts it into an ascending list held in a synchronous memory. Once
    // the item marked last has been stored (or dropped, if the list is full),
    // the emitter walks the list twice, merging in track 0, the head and the
    // highest track. The first walk delivers every position at or above the
    // head, the second every position below it, which is the circular-scan
    // order. The result register sits between the emitter and the output, and
    // the walk stalls on a kept position while a finished item waits there.

    typedef enum logic [1:0] {T_IDLE, T_INS, T_EMIT} t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_last, n_last;

    t_cfg               cfg;
    t_ins_req           ins_req;
    logic               ins_done;
    t_emit_req          emit_req;
    logic               emit_done;
    t_rd_req            rd_req;
    logic [TRACK_W-1:0] rd_data;
    logic               in_acc;
    logic [TRACK_W-1:0] req_sat;

    cscan_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cscan_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ins      (ins_req),
        .o_ins_done (ins_done),
        .i_rd       (rd_req),
        .o_rd_data  (rd_data)
    );

    cscan_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_start          (emit_req),
        .o_done           (emit_done),
        .o_rd             (rd_req),
        .i_rd_data        (rd_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_service_track  (o_service_track),
        .o_move_distance  (o_move_distance),
        .o_total_movement (o_total_movement),
        .o_last_out       (o_last_out)
    );

    // A request item is taken only while idle; the store and the
    // emitter share the memory, so only one of them runs at a time.
    assign o_in_ready = (r_state == T_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign req_sat    = sat_track(i_request_track, cfg.top);

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_last         = r_last;
        ins_req.start  = 1'b0;
        ins_req.value  = req_sat;
        ins_req.count  = r_count[ADDR_W-1:0];
        emit_req.start = 1'b0;
        emit_req.count = r_count;
        unique case (r_state)
            T_IDLE: begin
                if (in_acc) begin
                    if (r_count < CNT_W'(MAX_REQUESTS)) begin
                        ins_req.start = 1'b1;
                        n_last        = i_last_request;
                        n_state       = T_INS;
                    end else if (i_last_request) begin
                        // The list is full: the request is dropped, but its
                        // last mark still starts the schedule.
                        emit_req.start = 1'b1;
                        n_state        = T_EMIT;
                    end
                end
            end
            T_INS: begin
                if (ins_done) begin
                    n_count = r_count + 1'b1;
                    if (r_last) begin
                        emit_req.start = 1'b1;
                        emit_req.count = n_count;
                        n_state        = T_EMIT;
                    end else begin
                        n_state = T_IDLE;
                    end
                end
            end
            T_EMIT: begin
                if (emit_done) begin
                    n_count = '0;
                    n_state = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_count <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_last  <= n_last;
        end
    end

    // The stored request count never passes the list size.
    `CSCAN_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_REQUESTS))
    // The store reports a finished insertion only while one is pending.
    `CSCAN_ASSERT_IMP(a_ins_done_phase, i_clk, i_rst_n, ins_done, r_state == T_INS)
    // The emitter finishes only inside the emission phase.
    `CSCAN_ASSERT_IMP(a_emit_done_phase, i_clk, i_rst_n, emit_done, r_state == T_EMIT)
    // A request taken while the list has room always starts an insertion.
    `CSCAN_ASSERT_NEXT(a_acc_inserts, i_clk, i_rst_n,
        in_acc && (r_count < CNT_W'(MAX_REQUESTS)), r_state == T_INS)

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cscan_pkg::*;

    // One scheduled position as the block should report it.
    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic [TRACK_W-1:0] distance;
        logic [SUM_W-1:0]   total;
        logic               last;
    } service_stop_t;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = REG_HEAD;
    logic [TOTAL_W-1:0]   i_cfg_data      = '0;
    logic                 i_in_valid      = 1'b0;
    logic [TRACK_W-1:0]   i_request_track = '0;
    logic                 i_last_request  = 1'b0;
    logic                 i_out_ready     = 1'b0;

    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [TRACK_W-1:0]   o_service_track;
    logic [TRACK_W-1:0]   o_move_distance;
    logic [SUM_W-1:0]     o_total_movement;
    logic                 o_last_out;

    // Our own copy of the scheduler state: the two registers and the
    // requests loaded so far in the current batch.
    logic [TRACK_W-1:0]   head_track;
    logic [TOTAL_W-1:0]   track_count;
    logic [TRACK_W-1:0]   batch_tracks[$];

    // Positions still owed by the block, oldest first.
    service_stop_t        expected_stops[$];
    int                   stop_mismatches = 0;

    // When set, neither the request side nor the schedule side idles.
    bit                   steady_run = 1'b0;

    cscan_disk_scheduler DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_request_track  (i_request_track),
        .i_last_request   (i_last_request),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_service_track  (o_service_track),
        .o_move_distance  (o_move_distance),
        .o_total_movement (o_total_movement),
        .o_last_out       (o_last_out)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Highest track on the disk: the track count minus one, held at zero for
    // an empty disk and limited to what a track number can hold.
    function automatic logic [TRACK_W-1:0] highest_track();
        if (track_count == '0)
            return '0;
        if (track_count - 1'b1 > TOTAL_W'(TRACK_MAX))
            return TRACK_MAX;
        return TRACK_W'(track_count - 1'b1);
    endfunction

    // Builds the whole C-SCAN schedule for the batch just closed. Stored
    // requests are clamped again to the current top, then sorted together
    // with track 0, the head and the top. Service starts at the first copy
    // of the head, runs up to the top, wraps to track 0 and continues up to
    // just below the head copy.
    task automatic plan_service_order();
        logic [TRACK_W-1:0] order[MAX_REQUESTS+3];
        logic [TRACK_W-1:0] top;
        logic [TRACK_W-1:0] v;
        logic [TRACK_W-1:0] prev;
        logic [TRACK_W-1:0] step_dist;
        logic [SUM_W-1:0]   sum;
        service_stop_t      stop;
        int                 n;
        int                 i;
        int                 j;
        int                 k;
        top = highest_track();
        n = 0;
        for (i = 0; i < batch_tracks.size(); i++) begin
            order[n] = (batch_tracks[i] > top) ? top : batch_tracks[i];
            n++;
        end
        order[n] = '0;
        n++;
        order[n] = head_track;
        n++;
        order[n] = top;
        n++;
        for (i = 1; i < n; i++) begin
            v = order[i];
            j = i;
            while (j > 0 && order[j-1] > v) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
        end
        k = 0;
        while (order[k] != head_track)
            k++;
        sum  = '0;
        prev = '0;
        for (i = 0; i < n; i++) begin
            v = order[(k + i) % n];
            if (i == 0)
                step_dist = '0;
            else
                step_dist = (v >= prev) ? v - prev : prev - v;
            sum            = sum + SUM_W'(step_dist);
            stop.track     = v;
            stop.distance  = step_dist;
            stop.total     = sum;
            stop.last      = (i == n - 1);
            expected_stops.push_back(stop);
            prev = v;
        end
        batch_tracks.delete();
    endtask

    // Tracks one accepted request. The store keeps at most MAX_REQUESTS
    // requests; extra ones are dropped, but a last mark on a dropped request
    // still closes the batch.
    task automatic load_request(input logic [TRACK_W-1:0] track, input logic last);
        logic [TRACK_W-1:0] top;
        top = highest_track();
        if (batch_tracks.size() < MAX_REQUESTS)
            batch_tracks.push_back((track > top) ? top : track);
        if (last)
            plan_service_order();
    endtask

    // Idle length between items: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one request and returns in the time step of its acceptance,
    // with valid still high so that a back-to-back item keeps it high.
    task automatic send_request(input logic [TRACK_W-1:0] track, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_request_track <= track;
        i_last_request  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        load_request(track, last);
    endtask

    // Register write, only once the block has gone quiet: every owed position
    // has come out, and then enough cycles pass for an insertion walk through
    // a full store to end, since a request without a last mark gives no sign
    // of when it is done.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [TOTAL_W-1:0] value);
        i_in_valid <= 1'b0;
        while (expected_stops.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_index <= index;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == REG_HEAD)
            head_track = value[TRACK_W-1:0];
        else
            track_count = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Back-pressure on the schedule side: mostly ready, with short and
    // occasionally long stalls unless a steady stretch is running.
    always @(posedge i_clk) begin
        int stall_left;
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (!steady_run && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compares each accepted position with the oldest one owed.
    always @(posedge i_clk) begin
        service_stop_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_stops.size() == 0) begin
                stop_mismatches++;
                if (stop_mismatches <= 10)
                    $display("%0t: unexpected position track=%0d dist=%0d total=%0d last=%0b",
                             $realtime, o_service_track, o_move_distance,
                             o_total_movement, o_last_out);
            end else begin
                want = expected_stops.pop_front();
                if (o_service_track !== want.track || o_move_distance !== want.distance ||
                    o_total_movement !== want.total || o_last_out !== want.last) begin
                    stop_mismatches++;
                    if (stop_mismatches <= 10)
                        $display({"%0t: position mismatch: expected track=%0d dist=%0d ",
                                  "total=%0d last=%0b, got track=%0d dist=%0d total=%0d ",
                                  "last=%0b"},
                                 $realtime, want.track, want.distance, want.total,
                                 want.last, o_service_track, o_move_distance,
                                 o_total_movement, o_last_out);
                end
            end
        end
    end

    // A batch of one request closes at once, so the schedule is the request
    // plus track 0, the head and the top.
    task automatic test_single_request();
        write_register(REG_HEAD, TOTAL_W'(100));
        send_request(16'hFFFF, 1'b1);
        send_request(16'h0000, 1'b1);
    endtask

    // Extreme register and request values. Head data with the spare top bit
    // set must lose it, an oversized track count is limited to the widest
    // track number, and a one-track disk squeezes everything onto track 0.
    task automatic test_extremes();
        write_register(REG_HEAD, '1);
        write_register(REG_TOTAL, '1);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0001, 1'b0);
        send_request(16'h8000, 1'b1);
        write_register(REG_HEAD, '0);
        write_register(REG_TOTAL, TOTAL_W'(1));
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b1);
    endtask

    // A head above the top track stays as it is in the sorted positions.
    task automatic test_head_above_top();
        write_register(REG_HEAD, TOTAL_W'(500));
        write_register(REG_TOTAL, TOTAL_W'(100));
        send_request(16'd50, 1'b0);
        send_request(16'd99, 1'b0);
        send_request(16'd300, 1'b1);
    endtask

    // A track count of zero puts the top at track 0.
    task automatic test_zero_tracks();
        write_register(REG_HEAD, TOTAL_W'(7));
        write_register(REG_TOTAL, '0);
        send_request(16'd5, 1'b0);
        send_request(16'd0, 1'b1);
    endtask

    // Shrinking the disk in the middle of a batch: the requests already
    // stored must be clamped to the new top when the schedule is built.
    task automatic test_midbatch_resize();
        write_register(REG_HEAD, TOTAL_W'(1000));
        write_register(REG_TOTAL, TOTAL_W'(65536));
        send_request(16'd20000, 1'b0);
        send_request(16'd3000, 1'b0);
        send_request(16'd1000, 1'b0);
        write_register(REG_TOTAL, TOTAL_W'(2000));
        write_register(REG_HEAD, TOTAL_W'(1500));
        send_request(16'd40000, 1'b1);
    endtask

    // Random batches with random contents and occasional new settings. The
    // first batch overflows the store with a last mark on a dropped request;
    // later ones are mostly short with a few long or overflowing ones.
    task automatic test_random_batches();
        logic [TOTAL_W-1:0] value;
        logic [TRACK_W-1:0] track;
        int                 sent;
        int                 batch;
        int                 size;
        int                 i;
        sent  = 0;
        batch = 0;
        while (sent < 160) begin
            steady_run = 1'b0;
            if (batch == 0 || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0:       value = '0;
                    1:       value = TOTAL_W'(TRACK_MAX);
                    2:       value = {1'b1, TRACK_W'($urandom)};
                    default: value = TOTAL_W'($urandom_range(0, 65535));
                endcase
                write_register(REG_HEAD, value);
                case ($urandom_range(0, 7))
                    0:       value = '0;
                    1:       value = TOTAL_W'($urandom_range(65537, 131071));
                    2:       value = TOTAL_W'($urandom_range(1, 64));
                    3:       value = TOTAL_W'(65536);
                    default: value = TOTAL_W'($urandom_range(1, 65536));
                endcase
                write_register(REG_TOTAL, value);
            end
            steady_run = ($urandom_range(0, 3) == 0);
            if (batch == 0)
                size = MAX_REQUESTS + 2;
            else if ($urandom_range(0, 7) == 0)
                size = $urandom_range(20, MAX_REQUESTS + 4);
            else
                size = $urandom_range(1, 8);
            for (i = 0; i < size; i++) begin
                // Bias some requests onto the head, the top and the ends of
                // the range so that duplicates and clamping are common.
                case ($urandom_range(0, 7))
                    0:       track = head_track;
                    1:       track = highest_track();
                    2:       track = '0;
                    3:       track = TRACK_MAX;
                    4:       track = head_track + TRACK_W'($urandom_range(0, 3));
                    default: track = TRACK_W'($urandom);
                endcase
                send_request(track, i == size - 1);
                sent++;
            end
            batch++;
        end
        steady_run = 1'b0;
    endtask

    initial begin
        head_track  = '0;
        track_count = TOTAL_W'(65536);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_request();
        test_extremes();
        test_head_above_top();
        test_zero_tracks();
        test_midbatch_resize();
        test_random_batches();

        // Drain: wait for every owed position, then give the block time to
        // show anything extra it might still emit.
        i_in_valid <= 1'b0;
        while (expected_stops.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (stop_mismatches == 0 && expected_stops.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
